// ===== design/modbus_rtu_master_transaction_core_assert.svh =====
// Assertion macros for the Modbus RTU master transaction core.
// Included by the top level; needs no other file.
`ifndef MODBUS_RTU_MASTER_TRANSACTION_CORE_ASSERT_SVH
`define MODBUS_RTU_MASTER_TRANSACTION_CORE_ASSERT_SVH

// same-cycle implication
`define MRTU_ASSERT_IMPLY(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("mrtu assertion failed");

// next-cycle implication
`define MRTU_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("mrtu assertion failed");

`endif

// ===== design/mrtu_pkg.sv =====
// Types, codes and constants of the Modbus RTU master transaction core.
// Used by every module of the block; depends on nothing.
package mrtu_pkg;

   localparam int unsigned RxCapacity        = 256;
   localparam int unsigned LostLimit         = 4;
   localparam int unsigned ResponseTimeoutUs = 100000;

   localparam int unsigned RxCountWidth  = $clog2(RxCapacity + 1);
   localparam int unsigned LostWidth     = 4;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 16;

   localparam logic [7:0]  FuncCode      = 8'h17;
   localparam logic [6:0]  WriteCountMax = 7'd120;
   localparam logic [15:0] CrcInit       = 16'hFFFF;
   localparam logic [15:0] CrcPoly       = 16'hA001;

   typedef enum logic [2:0] {
      OpTick      = 3'd0,
      OpStart     = 3'd1,
      OpTxReady   = 3'd2,
      OpRxByte    = 3'd3,
      OpTakeReply = 3'd4,
      OpCountLost = 3'd5
   } op_type;

   localparam logic [2:0] ModeDisabled = 3'd0;
   localparam logic [2:0] ModeIdle     = 3'd1;
   localparam logic [2:0] ModeSending  = 3'd2;
   localparam logic [2:0] ModeWaiting  = 3'd3;
   localparam logic [2:0] ModeReady    = 3'd4;
   localparam logic [2:0] ModeError    = 3'd5;

   typedef enum logic [5:0] {
      StDisabled = 6'b000001,
      StIdle     = 6'b000010,
      StSending  = 6'b000100,
      StWaiting  = 6'b001000,
      StReady    = 6'b010000,
      StError    = 6'b100000
   } state_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CsrEnable     = 3'd0,
      CsrNetAddress = 3'd1,
      CsrTickUs     = 3'd2,
      CsrCharTimeUs = 3'd3,
      CsrReadStart  = 3'd4,
      CsrReadCount  = 3'd5,
      CsrWriteStart = 3'd6,
      CsrWriteCount = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       rx_accepted;
      logic [7:0] rx_index;
      logic       op_ok;
      logic [2:0] mode;
      logic       connected;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  net_address;
      logic [15:0] tick_us;
      logic [15:0] read_start;
      logic [7:0]  read_count;
      logic [15:0] write_start;
      logic [6:0]  write_count;
      logic [18:0] complete_us;
      logic [16:0] error_us;
   } cfg_type;

   typedef struct packed {
      logic write;
      logic enable;
   } enable_evt_type;

   typedef struct packed {
      logic [7:0]  tx_byte;
      logic [15:0] crc_next;
   } tx_out_type;

endpackage

// ===== design/mrtu_csr.sv =====
// Configuration registers and derived gap thresholds of the Modbus RTU master.
// Depends on mrtu_pkg.
module mrtu_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mrtu_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [mrtu_pkg::CsrDataWidth-1:0]   csr_data,
   output mrtu_pkg::cfg_type                   cfg,
   output mrtu_pkg::enable_evt_type            enable_evt
);

   logic [7:0]  net_address_ff;
   logic [15:0] tick_us_ff;
   logic [15:0] read_start_ff;
   logic [7:0]  read_count_ff;
   logic [15:0] write_start_ff;
   logic [6:0]  write_count_ff;
   logic [18:0] complete_us_ff, complete_us_in;
   logic [16:0] error_us_ff, error_us_in;
   logic        wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   assign complete_us_in = 19'((20'(csr_data) * 20'd7) >> 1);
   assign error_us_in    = 17'((18'(csr_data) * 18'd3) >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         net_address_ff <= 8'hFF;
         tick_us_ff     <= '0;
         read_start_ff  <= '0;
         read_count_ff  <= 8'd1;
         write_start_ff <= '0;
         write_count_ff <= 7'd1;
         complete_us_ff <= '0;
         error_us_ff    <= '0;
      end else if (wr) begin
         unique case (mrtu_pkg::csr_index_type'(csr_index))
            mrtu_pkg::CsrEnable: begin
            end
            mrtu_pkg::CsrNetAddress: net_address_ff <= csr_data[7:0];
            mrtu_pkg::CsrTickUs:     tick_us_ff     <= csr_data;
            mrtu_pkg::CsrCharTimeUs: begin
               complete_us_ff <= complete_us_in;
               error_us_ff    <= error_us_in;
            end
            mrtu_pkg::CsrReadStart:  read_start_ff  <= csr_data;
            mrtu_pkg::CsrReadCount:  read_count_ff  <= csr_data[7:0];
            mrtu_pkg::CsrWriteStart: write_start_ff <= csr_data;
            mrtu_pkg::CsrWriteCount: write_count_ff <= csr_data[6:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.net_address = net_address_ff;
      cfg.tick_us     = tick_us_ff;
      cfg.read_start  = read_start_ff;
      cfg.read_count  = read_count_ff;
      cfg.write_start = write_start_ff;
      cfg.write_count = (write_count_ff > mrtu_pkg::WriteCountMax) ?
                        mrtu_pkg::WriteCountMax : write_count_ff;
      cfg.complete_us = complete_us_ff;
      cfg.error_us    = error_us_ff;
   end

   assign enable_evt.write  = wr &&
      (mrtu_pkg::csr_index_type'(csr_index) == mrtu_pkg::CsrEnable);
   assign enable_evt.enable = csr_data[0];

endmodule

// ===== design/mrtu_tx.sv =====
// Request frame byte selection and one-byte CRC-16 update.
// Depends on mrtu_pkg; combinational.
module mrtu_tx (
   input  logic [7:0]        tx_position,
   input  logic [7:0]        frame_length,
   input  logic [15:0]       crc_acc,
   input  mrtu_pkg::cfg_type cfg,
   output mrtu_pkg::tx_out_type tx_out
);

   localparam logic [7:0] PosAddress     = 8'd0;
   localparam logic [7:0] PosFunc        = 8'd1;
   localparam logic [7:0] PosReadHi      = 8'd2;
   localparam logic [7:0] PosReadLo      = 8'd3;
   localparam logic [7:0] PosReadCntHi   = 8'd4;
   localparam logic [7:0] PosReadCntLo   = 8'd5;
   localparam logic [7:0] PosWriteHi     = 8'd6;
   localparam logic [7:0] PosWriteLo     = 8'd7;
   localparam logic [7:0] PosWriteCntHi  = 8'd8;
   localparam logic [7:0] PosWriteCntLo  = 8'd9;
   localparam logic [7:0] PosByteCount   = 8'd10;

   logic [7:0]  frame_byte;
   logic [7:0]  data_len;
   logic [15:0] crc_step;

   always_comb begin
      case (tx_position)
         PosAddress:    frame_byte = cfg.net_address;
         PosFunc:       frame_byte = mrtu_pkg::FuncCode;
         PosReadHi:     frame_byte = cfg.read_start[15:8];
         PosReadLo:     frame_byte = cfg.read_start[7:0];
         PosReadCntHi:  frame_byte = 8'h00;
         PosReadCntLo:  frame_byte = cfg.read_count;
         PosWriteHi:    frame_byte = cfg.write_start[15:8];
         PosWriteLo:    frame_byte = cfg.write_start[7:0];
         PosWriteCntHi: frame_byte = 8'h00;
         PosWriteCntLo: frame_byte = {1'b0, cfg.write_count};
         PosByteCount:  frame_byte = {cfg.write_count, 1'b0};
         default:       frame_byte = 8'h00;
      endcase
   end

   always_comb begin
      crc_step = crc_acc ^ {8'h00, frame_byte};
      for (int i = 0; i < 8; i++) begin
         crc_step = crc_step[0] ? ((crc_step >> 1) ^ mrtu_pkg::CrcPoly) : (crc_step >> 1);
      end
   end

   assign data_len = frame_length - 8'd2;

   always_comb begin
      tx_out.crc_next = crc_acc;
      if (tx_position < data_len) begin
         tx_out.tx_byte  = frame_byte;
         tx_out.crc_next = crc_step;
      end else if (tx_position == data_len) begin
         tx_out.tx_byte  = crc_acc[7:0];
      end else begin
         tx_out.tx_byte  = crc_acc[15:8];
      end
   end

endmodule

// ===== design/modbus_rtu_master_transaction_core.sv =====
// Modbus RTU master transaction core (read/write multiple registers, function 0x17).
// Every accepted event beat has its result beat in the registered result stage on the
// next cycle, so the block sustains one event per clock while the input is not stalled;
// the one-byte CRC-16 update and the gap compares sit in that single stage.
// The input stalls while the result register is full and stalled downstream, and in
// the cycle of an enable register write.
// Gap thresholds are computed when char_time_us is written. Depends on mrtu_pkg,
// mrtu_csr, mrtu_tx and the assertion header.
`include "modbus_rtu_master_transaction_core_assert.svh"

module modbus_rtu_master_transaction_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mrtu_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mrtu_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mrtu_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [mrtu_pkg::CsrDataWidth-1:0]   csr_data
);

   mrtu_pkg::cfg_type        cfg;
   mrtu_pkg::enable_evt_type enable_evt;
   mrtu_pkg::tx_out_type     tx_out;

   mrtu_pkg::state_type                  state_ff, state_in;
   logic [7:0]                           tx_position_ff, tx_position_in;
   logic [7:0]                           frame_length_ff, frame_length_in;
   logic [mrtu_pkg::RxCountWidth-1:0]    rx_count_ff, rx_count_in;
   logic [31:0]                          elapsed_ff, elapsed_in;
   logic [15:0]                          crc_ff, crc_in;
   logic [mrtu_pkg::LostWidth-1:0]       lost_count_ff, lost_count_in;
   logic                                 rsp_valid_ff;
   mrtu_pkg::rsp_type                    rsp_data_ff, rsp_data_in;

   logic        accept;
   logic [32:0] elapsed_sum;
   logic [31:0] elapsed_sat;

   mrtu_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cfg        (cfg),
      .enable_evt (enable_evt)
   );

   mrtu_tx u_tx (
      .tx_position  (tx_position_ff),
      .frame_length (frame_length_ff),
      .crc_acc      (crc_ff),
      .cfg          (cfg),
      .tx_out       (tx_out)
   );

   function automatic logic [2:0] mode_code(mrtu_pkg::state_type s);
      logic [2:0] m;
      unique case (s)
         mrtu_pkg::StDisabled: m = mrtu_pkg::ModeDisabled;
         mrtu_pkg::StIdle:     m = mrtu_pkg::ModeIdle;
         mrtu_pkg::StSending:  m = mrtu_pkg::ModeSending;
         mrtu_pkg::StWaiting:  m = mrtu_pkg::ModeWaiting;
         mrtu_pkg::StReady:    m = mrtu_pkg::ModeReady;
         mrtu_pkg::StError:    m = mrtu_pkg::ModeError;
         default:              m = mrtu_pkg::ModeDisabled;
      endcase
      return m;
   endfunction

   assign req_stall = (rsp_valid_ff && rsp_stall) || enable_evt.write;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign elapsed_sum = {1'b0, elapsed_ff} + 33'(cfg.tick_us);
   assign elapsed_sat = elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];

   always_comb begin
      state_in        = state_ff;
      tx_position_in  = tx_position_ff;
      frame_length_in = frame_length_ff;
      rx_count_in     = rx_count_ff;
      elapsed_in      = elapsed_ff;
      crc_in          = crc_ff;
      lost_count_in   = lost_count_ff;
      rsp_data_in     = '0;

      if (enable_evt.write) begin
         if (enable_evt.enable) begin
            state_in      = mrtu_pkg::StIdle;
            rx_count_in   = '0;
            elapsed_in    = '0;
            lost_count_in = mrtu_pkg::LostWidth'(mrtu_pkg::LostLimit);
         end else begin
            state_in = mrtu_pkg::StDisabled;
         end
      end else if (accept) begin
         unique case (mrtu_pkg::op_type'(req_data.operation))
            mrtu_pkg::OpTick: begin
               if (state_ff != mrtu_pkg::StDisabled) begin
                  elapsed_in = elapsed_sat;
                  if (state_ff == mrtu_pkg::StWaiting) begin
                     if (rx_count_ff == '0) begin
                        if (elapsed_sat > 32'(mrtu_pkg::ResponseTimeoutUs)) begin
                           state_in = mrtu_pkg::StIdle;
                        end
                     end else if (elapsed_sat > 32'(cfg.complete_us)) begin
                        state_in      = mrtu_pkg::StReady;
                        lost_count_in = '0;
                     end
                  end
                  if (state_ff == mrtu_pkg::StError && elapsed_sat > 32'(cfg.complete_us)) begin
                     state_in = mrtu_pkg::StIdle;
                  end
               end
            end
            mrtu_pkg::OpStart: begin
               if (state_ff == mrtu_pkg::StIdle) begin
                  frame_length_in = 8'd13 + {cfg.write_count, 1'b0};
                  tx_position_in  = '0;
                  elapsed_in      = '0;
                  crc_in          = mrtu_pkg::CrcInit;
                  state_in        = mrtu_pkg::StSending;
               end
               rsp_data_in.op_ok = (state_ff == mrtu_pkg::StIdle) ||
                                   (state_ff == mrtu_pkg::StSending);
            end
            mrtu_pkg::OpTxReady: begin
               if (state_ff == mrtu_pkg::StSending) begin
                  if (tx_position_ff < frame_length_ff) begin
                     rsp_data_in.tx_valid = 1'b1;
                     rsp_data_in.tx_byte  = tx_out.tx_byte;
                     crc_in               = tx_out.crc_next;
                     tx_position_in       = tx_position_ff + 8'd1;
                  end else begin
                     state_in       = mrtu_pkg::StWaiting;
                     tx_position_in = '0;
                     rx_count_in    = '0;
                     elapsed_in     = '0;
                  end
               end
            end
            mrtu_pkg::OpRxByte: begin
               if (state_ff == mrtu_pkg::StWaiting) begin
                  if (rx_count_ff < mrtu_pkg::RxCountWidth'(mrtu_pkg::RxCapacity) &&
                      elapsed_ff < 32'(cfg.error_us)) begin
                     rsp_data_in.rx_accepted = 1'b1;
                     rsp_data_in.rx_index    = 8'(rx_count_ff);
                     rx_count_in             = rx_count_ff + 1'b1;
                  end else begin
                     state_in = mrtu_pkg::StError;
                  end
                  elapsed_in = '0;
               end
               if (state_ff == mrtu_pkg::StError) begin
                  elapsed_in = '0;
               end
            end
            mrtu_pkg::OpTakeReply: begin
               if (state_ff == mrtu_pkg::StReady) begin
                  rsp_data_in.op_ok = 1'b1;
                  state_in          = mrtu_pkg::StIdle;
               end
            end
            mrtu_pkg::OpCountLost: begin
               if (lost_count_ff < mrtu_pkg::LostWidth'(mrtu_pkg::LostLimit)) begin
                  lost_count_in = lost_count_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      rsp_data_in.mode      = mode_code(state_in);
      rsp_data_in.connected = lost_count_in < mrtu_pkg::LostWidth'(mrtu_pkg::LostLimit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= mrtu_pkg::StDisabled;
         tx_position_ff  <= '0;
         frame_length_ff <= '0;
         rx_count_ff     <= '0;
         elapsed_ff      <= '0;
         crc_ff          <= mrtu_pkg::CrcInit;
         lost_count_ff   <= mrtu_pkg::LostWidth'(mrtu_pkg::LostLimit);
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         tx_position_ff  <= tx_position_in;
         frame_length_ff <= frame_length_in;
         rx_count_ff     <= rx_count_in;
         elapsed_ff      <= elapsed_in;
         crc_ff          <= crc_in;
         lost_count_ff   <= lost_count_in;
         if (accept && !enable_evt.write) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !enable_evt.write) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `MRTU_ASSERT_NEXT(a_rsp_follows_req, clock, reset,
      req_valid && !req_stall && !(csr_valid && csr_ready), rsp_valid)
   `MRTU_ASSERT_IMPLY(a_tx_only_sending, clock, reset,
      rsp_valid && rsp_data.tx_valid, rsp_data.mode == mrtu_pkg::ModeSending)
   `MRTU_ASSERT_IMPLY(a_rx_only_waiting, clock, reset,
      rsp_valid && rsp_data.rx_accepted, rsp_data.mode == mrtu_pkg::ModeWaiting)
   `MRTU_ASSERT_IMPLY(a_lost_in_range, clock, reset,
      1'b1, lost_count_ff <= mrtu_pkg::LostWidth'(mrtu_pkg::LostLimit))

endmodule
